FILE: rtl/least_loaded_server_table_core_macros.svh
// Assertion macros for the least-loaded server table core.
`ifndef LEAST_LOADED_SERVER_TABLE_CORE_MACROS_SVH
`define LEAST_LOADED_SERVER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define LLST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define LLST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/llst_pkg.sv
// Shared constants, types and helpers for the least-loaded server table.
package llst_pkg;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ID_W       = 32;
   localparam int FUNC_W     = 3;
   localparam int RSP_CNT_W  = 16;
   localparam int LIM_W      = COUNT_BITS + 32;

   localparam logic [31:0]           LOAD_LIMIT = 32'd9999;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

   localparam logic [FUNC_W-1:0] FUNC_INIT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_PICK   = 3'd5;

   // Scan record passed down the cell row.
   typedef struct packed {
      logic                  valid;
      logic [FUNC_W-1:0]     func;
      logic [ID_W-1:0]       server_id;
      logic [ID_W-1:0]       key;
      logic                  hit;
      logic [IDX_W-1:0]      hit_idx;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  free_found;
      logic [IDX_W-1:0]      free_idx;
      logic                  best_found;
      logic [COUNT_BITS-1:0] best_count;
      logic [ID_W-1:0]       best_id;
   } carry_type;

   // Write-back to one cell.
   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      idx;
      logic                  valid;
      logic [ID_W-1:0]       id;
      logic [COUNT_BITS-1:0] count;
   } wr_type;

   function automatic logic below_limit(input logic [COUNT_BITS-1:0] c);
      logic [LIM_W-1:0] w;
      w = {32'b0, c};
      return w < LIM_W'(LOAD_LIMIT);
   endfunction

   function automatic logic [RSP_CNT_W-1:0] rsp_count(input logic [COUNT_BITS-1:0] c);
      logic [RSP_CNT_W+COUNT_BITS-1:0] w;
      w = {{RSP_CNT_W{1'b0}}, c};
      return w[RSP_CNT_W-1:0];
   endfunction

endpackage

FILE: rtl/least_loaded_server_table_core.sv
// Top level of the least-loaded server table: cell row, control and ports.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   req      | req_valid/req_ready  | req_func, req_server_id
//   rsp      | rsp_valid/rsp_ready  | rsp_found, rsp_session_count,
//            |                      | rsp_chosen_server, rsp_table_full
//   csr      | csr_valid/csr_ready  | csr_fallback_server
//
// A transaction walks its scan record down the cell row one cell per cycle, then
// passes through the decide and write states and returns to idle before the next
// req is taken.
// Reset clears all entry valid bits at once; fallback_server resets to 1.
// A stalled rsp holds the decide step; a new req is taken as soon as the write ends.
`include "least_loaded_server_table_core_macros.svh"

module least_loaded_server_table_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_func,
   input  logic [31:0]                   req_server_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [15:0]                   rsp_session_count,
   output logic [31:0]                   rsp_chosen_server,
   output logic                          rsp_table_full,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_fallback_server
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_WRITE  = 2'd3;

   logic [1:0]                      state_ff;
   logic [1:0]                      state_in;
   logic [31:0]                     fallback_ff;
   llst_pkg::carry_type             chain [llst_pkg::ENTRIES+1];
   logic [llst_pkg::ENTRIES:0]      carry_valids;
   llst_pkg::carry_type             fin_ff;
   llst_pkg::wr_type                wr_ff;
   llst_pkg::wr_type                dec_wr;
   logic                            dec_found;
   logic [llst_pkg::COUNT_BITS-1:0] dec_count;
   logic [31:0]                     dec_chosen;
   logic                            dec_full;
   logic                            ins_ok;
   logic                            is_op;
   logic                            req_take;
   logic                            rsp_load;
   logic                            rsp_valid_ff;
   logic                            rsp_found_ff;
   logic [15:0]                     rsp_session_count_ff;
   logic [31:0]                     rsp_chosen_server_ff;
   logic                            rsp_table_full_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      chain[0]           = '0;
      chain[0].valid     = req_take;
      chain[0].func      = req_func;
      chain[0].server_id = req_server_id;
      chain[0].key       = (req_func == llst_pkg::FUNC_PICK) ? fallback_ff : req_server_id;
   end

   for (genvar i = 0; i < llst_pkg::ENTRIES; i++) begin : g_cell
      llst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (llst_pkg::IDX_W'(i)),
         .up_carry   (chain[i]),
         .dn_carry   (chain[i+1]),
         .wr         (wr_ff)
      );
   end

   always_comb begin
      for (int k = 0; k <= llst_pkg::ENTRIES; k++) begin
         carry_valids[k] = chain[k].valid;
      end
   end

   // Decide from the finished scan record.
   always_comb begin
      ins_ok       = fin_ff.hit || fin_ff.free_found;
      is_op        = (fin_ff.func <= llst_pkg::FUNC_QUERY) && (fin_ff.server_id != '0);
      dec_found    = 1'b0;
      dec_count    = '0;
      dec_chosen   = '0;
      dec_full     = 1'b0;
      dec_wr       = '0;
      dec_wr.idx   = fin_ff.hit ? fin_ff.hit_idx : fin_ff.free_idx;
      dec_wr.valid = 1'b1;
      dec_wr.id    = fin_ff.key;
      if (fin_ff.func == llst_pkg::FUNC_PICK) begin
         if (fin_ff.best_found) begin
            dec_found  = 1'b1;
            dec_count  = fin_ff.best_count;
            dec_chosen = fin_ff.best_id;
         end else if (fin_ff.key != '0) begin
            dec_chosen = fin_ff.key;
            dec_found  = fin_ff.hit;
            if (ins_ok) begin
               dec_wr.en    = 1'b1;
               dec_wr.count = llst_pkg::COUNT_BITS'(1);
               dec_count    = llst_pkg::COUNT_BITS'(1);
            end else begin
               dec_full = 1'b1;
            end
         end
      end else if (is_op) begin
         dec_found = fin_ff.hit;
         case (fin_ff.func)
            llst_pkg::FUNC_INIT: begin
               if (ins_ok) begin
                  dec_wr.en = 1'b1;
               end else begin
                  dec_full = 1'b1;
               end
            end
            llst_pkg::FUNC_ADD: begin
               if (fin_ff.hit) begin
                  dec_wr.en    = 1'b1;
                  dec_wr.count = (fin_ff.hit_count == llst_pkg::COUNT_MAX) ?
                                 fin_ff.hit_count :
                                 fin_ff.hit_count + llst_pkg::COUNT_BITS'(1);
                  dec_count    = dec_wr.count;
               end else if (fin_ff.free_found) begin
                  dec_wr.en    = 1'b1;
                  dec_wr.count = llst_pkg::COUNT_BITS'(1);
                  dec_count    = llst_pkg::COUNT_BITS'(1);
               end else begin
                  dec_full = 1'b1;
               end
            end
            llst_pkg::FUNC_SUB: begin
               if (fin_ff.hit) begin
                  dec_wr.en    = 1'b1;
                  dec_wr.count = (fin_ff.hit_count == '0) ? fin_ff.hit_count :
                                 fin_ff.hit_count - llst_pkg::COUNT_BITS'(1);
                  dec_count    = dec_wr.count;
               end
            end
            llst_pkg::FUNC_REMOVE: begin
               if (fin_ff.hit) begin
                  dec_wr.en    = 1'b1;
                  dec_wr.valid = 1'b0;
               end
            end
            llst_pkg::FUNC_QUERY: begin
               dec_count = fin_ff.hit ? fin_ff.hit_count : '0;
            end
            default: begin
               dec_count = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_SCAN;
         ST_SCAN:   if (chain[llst_pkg::ENTRIES].valid) state_in = ST_DECIDE;
         ST_DECIDE: if (rsp_load) state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fallback_ff  <= 32'd1;
         wr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            fallback_ff <= csr_fallback_server;
         end
         if (rsp_load) begin
            wr_ff <= dec_wr;
         end else begin
            wr_ff.en <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && chain[llst_pkg::ENTRIES].valid) begin
         fin_ff <= chain[llst_pkg::ENTRIES];
      end
      if (rsp_load) begin
         rsp_found_ff         <= dec_found;
         rsp_session_count_ff <= llst_pkg::rsp_count(dec_count);
         rsp_chosen_server_ff <= dec_chosen;
         rsp_table_full_ff    <= dec_full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_session_count = rsp_session_count_ff;
   assign rsp_chosen_server = rsp_chosen_server_ff;
   assign rsp_table_full    = rsp_table_full_ff;

   `LLST_ASSERT_NOW(a_one_scan, clock, reset, 1'b1, $countones(carry_valids) <= 1, "two scans in flight")
   `LLST_ASSERT_NOW(a_scan_end, clock, reset, chain[llst_pkg::ENTRIES].valid, state_ff == ST_SCAN, "scan ended outside scan state")
   `LLST_ASSERT_NOW(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DECIDE, "response not from decide")
   `LLST_ASSERT_NOW(a_full_cnt, clock, reset, rsp_valid_ff && rsp_table_full_ff, rsp_session_count_ff == '0, "dropped insert with count")

endmodule

FILE: rtl/llst_cell.sv
// One table slot: holds an entry and updates the scan record passing through.
module llst_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [llst_pkg::IDX_W-1:0]    cell_index,
   input  llst_pkg::carry_type           up_carry,
   output llst_pkg::carry_type           dn_carry,
   input  llst_pkg::wr_type              wr
);

   logic                            valid_ff;
   logic [llst_pkg::ID_W-1:0]       id_ff;
   logic [llst_pkg::COUNT_BITS-1:0] count_ff;
   llst_pkg::carry_type             carry_ff;
   llst_pkg::carry_type             carry_in;
   logic                            take_best;

   always_comb begin
      take_best = valid_ff && llst_pkg::below_limit(count_ff) &&
                  (!up_carry.best_found || (count_ff < up_carry.best_count) ||
                   ((count_ff == up_carry.best_count) && (id_ff < up_carry.best_id)));
      carry_in = up_carry;
      if (up_carry.valid) begin
         if (valid_ff && (id_ff == up_carry.key) && !up_carry.hit) begin
            carry_in.hit       = 1'b1;
            carry_in.hit_idx   = cell_index;
            carry_in.hit_count = count_ff;
         end
         if (!valid_ff && !up_carry.free_found) begin
            carry_in.free_found = 1'b1;
            carry_in.free_idx   = cell_index;
         end
         if (take_best) begin
            carry_in.best_found = 1'b1;
            carry_in.best_count = count_ff;
            carry_in.best_id    = id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && (wr.idx == cell_index)) begin
         valid_ff <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_index)) begin
         id_ff    <= wr.id;
         count_ff <= wr.count;
      end
   end

   assign dn_carry = carry_ff;

endmodule
